/* design/telnet_ansi_key_decoder_defines.svh */
// Assertion macros shared by the telnet key decoder modules.
`ifndef TELNET_ANSI_KEY_DECODER_DEFINES_SVH
`define TELNET_ANSI_KEY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define TKD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define TKD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define TKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TKD_ASSERT_ALWAYS(label, clk, rst, cond, msg)

`define TKD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define TKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* design/tkd_pkg.sv */
// Types and byte constants of the telnet key decoder.
package tkd_pkg;

  localparam logic [7:0] BYTE_IAC    = 8'd255;
  localparam logic [7:0] BYTE_SB     = 8'd250;
  localparam logic [7:0] BYTE_SE     = 8'd240;
  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_CTRL_L = 8'd12;
  localparam logic [7:0] BYTE_CR     = 8'd13;
  localparam logic [7:0] BYTE_LF     = 8'd10;
  localparam logic [7:0] BYTE_NUL    = 8'd0;

  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;  // '['
  localparam logic [7:0] CHAR_O        = 8'h4F;  // 'O'
  localparam logic [7:0] CHAR_1        = 8'h31;  // '1'
  localparam logic [7:0] CHAR_4        = 8'h34;  // '4'
  localparam logic [7:0] CHAR_6        = 8'h36;  // '6'
  localparam logic [7:0] CHAR_TILDE    = 8'h7E;  // '~'
  localparam logic [7:0] CHAR_A        = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_D        = 8'h44;  // 'D'

  typedef enum logic [1:0] {
    KIND_PLAIN    = 2'd0,
    KIND_CURSOR   = 2'd1,
    KIND_FUNCTION = 2'd2,
    KIND_ESCAPE   = 2'd3
  } tkd_kind_t;

  // Byte handed from the telnet layer to the escape and line layers.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } tkd_up_t;

  // Key produced for one byte.
  typedef struct packed {
    logic       valid;
    tkd_kind_t  kind;
    logic [7:0] value;
  } tkd_key_t;

endpackage

/* design/tkd_telnet.sv */
// Telnet command stripper: removes IAC commands and passes bytes upward.
module tkd_telnet
  import tkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  output tkd_up_t    up
);

  `include "telnet_ansi_key_decoder_defines.svh"

  typedef enum logic [1:0] {
    TEL_IDLE    = 2'd0,
    TEL_AFTER   = 2'd1,
    TEL_SWALLOW = 2'd2,
    TEL_SUBNEG  = 2'd3
  } tel_state_t;

  tel_state_t tel_phase;
  tel_state_t tel_phase_next;

  always_comb begin
    tel_phase_next = tel_phase;
    up.valid       = 1'b0;
    up.ch          = BYTE_NUL;
    case (tel_phase)
      TEL_IDLE: begin
        if (rx_byte == BYTE_IAC) begin
          tel_phase_next = TEL_AFTER;
        end else begin
          up.valid = 1'b1;
          up.ch    = rx_byte;
        end
      end
      TEL_AFTER: begin
        tel_phase_next = (rx_byte == BYTE_SB) ? TEL_SUBNEG : TEL_SWALLOW;
      end
      TEL_SWALLOW: begin
        // finished command: hand a NUL upward
        tel_phase_next = TEL_IDLE;
        up.valid       = 1'b1;
      end
      TEL_SUBNEG: begin
        if (rx_byte == BYTE_SE) begin
          tel_phase_next = TEL_IDLE;
          up.valid       = 1'b1;
        end
      end
      default: begin
        tel_phase_next = TEL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tel_phase <= TEL_IDLE;
    end else if (advance) begin
      tel_phase <= tel_phase_next;
    end
  end

  `TKD_ASSERT_IMPLIES(a_no_byte_after_iac, clk, rst, tel_phase == TEL_AFTER, !up.valid,
                      "telnet layer passed a byte while reading a command code")

endmodule

/* design/tkd_keys.sv */
// Escape sequence and line layers: turn bytes into keys.
module tkd_keys
  import tkd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  tkd_up_t  up,
  output tkd_key_t key
);

  `include "telnet_ansi_key_decoder_defines.svh"

  typedef enum logic [2:0] {
    ESC_IDLE      = 3'd0,
    ESC_START     = 3'd1,
    ESC_CSI       = 3'd2,
    ESC_FN        = 3'd3,
    ESC_MALFORMED = 3'd4
  } esc_state_t;

  esc_state_t esc_phase;
  esc_state_t esc_phase_next;
  logic [7:0] prev_byte;
  logic [7:0] prev_byte_next;
  logic       after_cr;
  logic       after_cr_next;

  logic [7:0] ch;
  logic       ch_is_digit;
  logic       prev_is_digit;

  assign ch            = up.ch;
  assign ch_is_digit   = (ch >= CHAR_1) && (ch <= CHAR_6);
  assign prev_is_digit = (prev_byte >= CHAR_1) && (prev_byte <= CHAR_6);

  always_comb begin
    esc_phase_next = esc_phase;
    prev_byte_next = prev_byte;
    after_cr_next  = after_cr;
    key.valid      = 1'b0;
    key.kind       = KIND_PLAIN;
    key.value      = ch;
    case (esc_phase)
      ESC_START: begin
        if ((ch == CHAR_LBRACKET) || (ch == CHAR_O)) begin
          esc_phase_next = ESC_CSI;
          prev_byte_next = ch;
        end else if ((ch == CHAR_1) || (ch == CHAR_4)) begin
          esc_phase_next = ESC_FN;
          prev_byte_next = ch;
        end else begin
          esc_phase_next = ESC_IDLE;
          key.valid      = 1'b1;
          key.kind       = KIND_ESCAPE;
          key.value      = BYTE_ESC;
        end
      end
      ESC_CSI: begin
        if ((ch >= CHAR_A) && (ch <= CHAR_D)) begin
          esc_phase_next = ESC_IDLE;
          key.valid      = 1'b1;
          key.kind       = KIND_CURSOR;
          key.value      = ch - CHAR_A;
        end else begin
          esc_phase_next = ch_is_digit ? ESC_FN : ESC_MALFORMED;
          prev_byte_next = ch;
        end
      end
      ESC_FN: begin
        if ((ch == CHAR_TILDE) && prev_is_digit) begin
          esc_phase_next = ESC_IDLE;
          key.valid      = 1'b1;
          key.kind       = KIND_FUNCTION;
          key.value      = prev_byte - CHAR_1;
        end else begin
          esc_phase_next = ESC_MALFORMED;
          prev_byte_next = ch;
        end
      end
      ESC_MALFORMED: begin
        // pass the byte straight through, bypassing the line layer
        esc_phase_next = ESC_IDLE;
        key.valid      = 1'b1;
      end
      default: begin
        esc_phase_next = ESC_IDLE;
        if (ch == BYTE_ESC) begin
          esc_phase_next = ESC_START;
        end else if (ch == BYTE_CTRL_L) begin
          key.valid = 1'b0;
        end else if (ch == BYTE_CR) begin
          after_cr_next = 1'b1;
          key.valid     = 1'b1;
          key.value     = BYTE_LF;
        end else if ((ch == BYTE_LF) && after_cr) begin
          after_cr_next = 1'b0;
        end else begin
          after_cr_next = 1'b0;
          key.valid     = (ch != BYTE_NUL);
        end
      end
    endcase
    if (!up.valid) begin
      key.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_phase <= ESC_IDLE;
      prev_byte <= BYTE_NUL;
      after_cr  <= 1'b0;
    end else if (advance && up.valid) begin
      esc_phase <= esc_phase_next;
      prev_byte <= prev_byte_next;
      after_cr  <= after_cr_next;
    end
  end

  `TKD_ASSERT_IMPLIES(a_fn_prev_digit, clk, rst, esc_phase == ESC_FN, prev_is_digit,
                      "function stage entered without a digit held")

endmodule

/* design/telnet_ansi_key_decoder.sv */
// Top level of the telnet key decoder: input register, decode, result register.
//
// Takes one raw telnet byte per request and gives at most one key per byte.
// Telnet IAC commands are stripped first (IAC SB ... SE and IAC x y), each
// finished command passing a NUL upward; ESC sequences then become cursor
// keys (kind 1, value 0-3 for A-D), function keys (kind 2, value 0-5 for
// digits 1-6) or a lone escape (kind 3, value 27); the remaining bytes go out
// as plain keys (kind 0) with CR turned into LF, an LF right after a CR
// dropped, and NUL and Ctrl-L dropped. A byte that closes no key gives no
// result. Throughput is one byte per clock cycle while the output is not
// stalled; a byte waits in the input register and its key in the result
// register. A single decode pass runs combinationally from the input register
// through the telnet and key layers into the result register. Both sides use
// a valid/ready handshake; while a finished key waits on the output, one more
// byte is taken into the input register and held there until the key is taken.
module telnet_ansi_key_decoder
  import tkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] key_value
  output logic [1:0] m_tuser    // [1:0] key_kind
);

  `include "telnet_ansi_key_decoder_defines.svh"

  // Input register: one received byte waiting for decode.
  logic       in_valid;
  logic [7:0] in_byte;

  // Result register.
  logic       out_valid;
  tkd_kind_t  out_kind;
  logic [7:0] out_value;

  logic     advance;
  tkd_up_t  up;
  tkd_key_t key;

  // Decode the held byte once the result register can take its outcome.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  tkd_telnet u_telnet (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (in_byte),
    .up      (up)
  );

  tkd_keys u_keys (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .up      (up),
    .key     (key)
  );

  // Hold the incoming byte until decode takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Load a key when decode yields one; drop the register once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= key.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && key.valid) begin
      out_kind  <= key.kind;
      out_value <= key.value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_kind;

  `TKD_ASSERT_IMPLIES(a_cursor_range, clk, rst, m_tvalid && (m_tuser == KIND_CURSOR),
                      m_tdata[7:2] == 6'd0, "cursor key index out of range")
  `TKD_ASSERT_IMPLIES(a_fn_range, clk, rst, m_tvalid && (m_tuser == KIND_FUNCTION),
                      m_tdata <= 8'd5, "function key index out of range")
  `TKD_ASSERT_IMPLIES(a_escape_value, clk, rst, m_tvalid && (m_tuser == KIND_ESCAPE),
                      m_tdata == BYTE_ESC, "lone escape carries a wrong value")
  `TKD_ASSERT_NEXT(a_hold_without_decode, clk, rst, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser),
                   "stalled key changed without being taken")

endmodule

/* verif/telnet_ansi_key_decoder_tb.sv */
// Self-checking testbench of the telnet key decoder: stream driver, predictor and key monitor.
module telnet_ansi_key_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tkd_pkg::*;

  localparam int RANDOM_BYTES = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TIME  = 12;

  // Telnet command layer states.
  typedef enum logic [1:0] {
    TN_IDLE, TN_AFTER_IAC, TN_SWALLOW, TN_SUBNEG
  } tn_state_t;

  // Escape layer states.
  typedef enum logic [2:0] {
    ESC_IDLE, ESC_START, ESC_BRACKET, ESC_DIGIT, ESC_BROKEN
  } esc_state_t;

  typedef struct {
    tkd_kind_t  kind;
    logic [7:0] value;
  } key_t;

  typedef struct {
    logic [7:0] rx;
    bit         hold_for_drain;  // wait until every key is out before offering it
  } rx_request_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] rx_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] key_value
  logic [1:0] m_tuser;          // [1:0] key_kind

  telnet_ansi_key_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Predictor state, mirroring the block after each accepted byte.
  tn_state_t  tn_state = TN_IDLE;
  esc_state_t esc_state = ESC_IDLE;
  logic [7:0] last_esc_byte = 8'd0;
  bit         cr_seen = 1'b0;

  rx_request_t pending_bytes[$];
  key_t        expected_keys[$];

  int  queued_bytes = 0;
  int  accepted_bytes = 0;
  int  checked_keys = 0;
  int  kind_count[4] = '{0, 0, 0, 0};
  int  failures = 0;
  int  cycle_count = 0;
  bit  drain_next = 1'b0;
  int  calm_left[2] = '{0, 0};   // index 0 sender, 1 receiver

  function automatic void emit_key(input tkd_kind_t kind, input logic [7:0] value);
    key_t k;
    k.kind  = kind;
    k.value = value;
    expected_keys.push_back(k);
  endfunction

  function automatic bit is_fn_digit(input logic [7:0] c);
    return c >= CHAR_1 && c <= CHAR_6;
  endfunction

  // Escape and line layers: take one byte handed up by the telnet layer.
  function automatic void feed_key_layers(input logic [7:0] ch);
    if (esc_state != ESC_IDLE) begin
      case (esc_state)
        ESC_START: begin
          if (ch == CHAR_LBRACKET || ch == CHAR_O) begin
            esc_state = ESC_BRACKET;
          end else if (ch == CHAR_1 || ch == CHAR_4) begin
            esc_state = ESC_DIGIT;
          end else begin
            // anything else, a second ESC or a virtual NUL too, closes a lone escape
            esc_state = ESC_IDLE;
            emit_key(KIND_ESCAPE, BYTE_ESC);
            return;
          end
        end
        ESC_BRACKET: begin
          if (ch >= CHAR_A && ch <= CHAR_D) begin
            esc_state = ESC_IDLE;
            emit_key(KIND_CURSOR, ch - CHAR_A);
            return;
          end
          esc_state = is_fn_digit(ch) ? ESC_DIGIT : ESC_BROKEN;
        end
        ESC_DIGIT: begin
          if (ch == CHAR_TILDE && is_fn_digit(last_esc_byte)) begin
            esc_state = ESC_IDLE;
            emit_key(KIND_FUNCTION, last_esc_byte - CHAR_1);
            return;
          end
          esc_state = ESC_BROKEN;
        end
        default: begin
          // after a broken sequence the byte goes out raw, past the line layer
          esc_state = ESC_IDLE;
          emit_key(KIND_PLAIN, ch);
          return;
        end
      endcase
      last_esc_byte = ch;
      return;
    end
    if (ch == BYTE_ESC) begin
      esc_state = ESC_START;
      return;
    end
    if (ch == BYTE_CTRL_L) return;
    if (ch == BYTE_CR) begin
      cr_seen = 1'b1;
      emit_key(KIND_PLAIN, BYTE_LF);
      return;
    end
    if (ch == BYTE_LF && cr_seen) begin
      cr_seen = 1'b0;
      return;
    end
    cr_seen = 1'b0;
    if (ch != BYTE_NUL) emit_key(KIND_PLAIN, ch);
  endfunction

  // Telnet layer: strip IAC commands, a finished one passes a NUL upward.
  function automatic void decode_rx_byte(input logic [7:0] b);
    case (tn_state)
      TN_AFTER_IAC: tn_state = (b == BYTE_SB) ? TN_SUBNEG : TN_SWALLOW;
      TN_SWALLOW: begin
        tn_state = TN_IDLE;
        feed_key_layers(BYTE_NUL);
      end
      TN_SUBNEG: begin
        if (b == BYTE_SE) begin
          tn_state = TN_IDLE;
          feed_key_layers(BYTE_NUL);
        end
      end
      default: begin
        if (b == BYTE_IAC) tn_state = TN_AFTER_IAC;
        else feed_key_layers(b);
      end
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    rx_request_t r;
    r.rx = b;
    r.hold_for_drain = drain_next;
    drain_next = 1'b0;
    pending_bytes.push_back(r);
    queued_bytes++;
  endfunction

  // Mostly short pauses, a few long ones, and now and then a calm stretch of none.
  function automatic int draw_pause(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queue one random sequence: mostly well-formed keys and commands, some noise.
  task automatic add_random_sequence();
    int pick;
    int n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(1, 4);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 40) begin
      push_byte(BYTE_ESC);
      push_byte($urandom_range(0, 1) ? CHAR_LBRACKET : CHAR_O);
      push_byte(8'(CHAR_A + $urandom_range(0, 3)));
    end else if (pick < 55) begin
      push_byte(BYTE_ESC);
      if ($urandom_range(0, 2) != 0) begin
        push_byte($urandom_range(0, 1) ? CHAR_LBRACKET : CHAR_O);
        push_byte(8'(CHAR_1 + $urandom_range(0, 5)));
      end else begin
        push_byte($urandom_range(0, 1) ? CHAR_1 : CHAR_4);
      end
      push_byte(CHAR_TILDE);
    end else if (pick < 65) begin
      // broken escape: bytes close to the real ones, mixed with random bytes
      push_byte(BYTE_ESC);
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: b = CHAR_LBRACKET;
          1: b = CHAR_O;
          2: b = 8'(CHAR_1 + $urandom_range(0, 8));
          3: b = CHAR_TILDE;
          4: b = 8'(CHAR_A + $urandom_range(0, 5));
          5: b = BYTE_CR;
          6: b = BYTE_ESC;
          default: b = 8'($urandom_range(0, 255));
        endcase
        push_byte(b);
      end
    end else if (pick < 80) begin
      push_byte(BYTE_IAC);
      if ($urandom_range(0, 1)) begin
        push_byte(BYTE_SB);
        n = $urandom_range(0, 4);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == BYTE_SE) b = 8'hF1;
          push_byte(b);
        end
        push_byte(BYTE_SE);
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == BYTE_SB) b = BYTE_IAC;
        push_byte(b);
        push_byte(8'($urandom_range(0, 255)));
      end
    end else if (pick < 90) begin
      case ($urandom_range(0, 4))
        0: push_byte(BYTE_CTRL_L);
        1: push_byte(BYTE_NUL);
        2: begin
          push_byte(BYTE_CR);
          push_byte(BYTE_CR);
        end
        default: push_byte(BYTE_CR);
      endcase
      push_byte($urandom_range(0, 1) ? BYTE_LF : 8'($urandom_range(0, 255)));
    end else begin
      // a telnet command landing in the middle of an escape sequence
      push_byte(BYTE_ESC);
      if ($urandom_range(0, 1)) push_byte(CHAR_LBRACKET);
      push_byte(BYTE_IAC);
      push_byte(8'($urandom_range(0, 255)));
      push_byte(8'($urandom_range(0, 255)));
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Driver: hand the next pending request over once the previous one is taken.
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_rx_byte(s_tdata);
        accepted_bytes++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].hold_for_drain && expected_keys.size() != 0)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_bytes[0].rx;
        pending_bytes.pop_front();
        gap_left = draw_pause(0);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = draw_pause(1);
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Monitor: check each key taken against the oldest prediction.
  always @(posedge clk) begin
    key_t exp_key;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_keys.size() == 0) begin
        $error("unexpected key: kind %0d value 0x%02h", m_tuser, m_tdata);
        failures++;
      end else begin
        exp_key = expected_keys.pop_front();
        if (m_tuser !== exp_key.kind) begin
          $error("key_kind: expected %0d, got %0d", exp_key.kind, m_tuser);
          failures++;
        end
        if (m_tdata !== exp_key.value) begin
          $error("key_value: expected 0x%02h, got 0x%02h", exp_key.value, m_tdata);
          failures++;
        end
        checked_keys++;
        kind_count[exp_key.kind]++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d keys still awaited",
               cycle_count, expected_keys.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int random_start;
    bit mid_drain_done;

    // Directed opening: line layer, every key kind, broken sequences, telnet cases.
    push_byte(8'hFE);                       // highest plain byte
    push_byte(BYTE_CR);                     // CR becomes LF ...
    push_byte(BYTE_LF);                     // ... and the LF after it is dropped
    push_byte(BYTE_CTRL_L);
    push_byte(BYTE_NUL);
    push_byte(BYTE_ESC);                    // cursor key through the O form
    push_byte(CHAR_O);
    push_byte(CHAR_D);
    push_byte(BYTE_ESC);                    // highest function key
    push_byte(CHAR_LBRACKET);
    push_byte(CHAR_6);
    push_byte(CHAR_TILDE);
    push_byte(BYTE_ESC);                    // short function form
    push_byte(CHAR_4);
    push_byte(CHAR_TILDE);
    push_byte(BYTE_ESC);                    // second escape closes a lone escape
    push_byte(BYTE_ESC);
    push_byte(BYTE_ESC);                    // broken sequence, CR passes raw
    push_byte(CHAR_LBRACKET);
    push_byte(8'h5A);
    push_byte(BYTE_CR);
    push_byte(BYTE_IAC);                    // empty subnegotiation
    push_byte(BYTE_SB);
    push_byte(BYTE_SE);
    push_byte(BYTE_ESC);                    // IAC IAC inside an escape
    push_byte(BYTE_IAC);
    push_byte(BYTE_IAC);
    push_byte(8'h41);

    drain_next = 1'b1;
    random_start = queued_bytes;
    mid_drain_done = 1'b0;
    while (queued_bytes - random_start < RANDOM_BYTES) begin
      if (!mid_drain_done && queued_bytes - random_start > RANDOM_BYTES / 2) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      add_random_sequence();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);

    $display("Sent %0d telnet bytes and checked %0d keys in %0d cycles",
             accepted_bytes, checked_keys, cycle_count);
    $display("Keys by kind: plain %0d, cursor %0d, function %0d, lone escape %0d",
             kind_count[KIND_PLAIN], kind_count[KIND_CURSOR],
             kind_count[KIND_FUNCTION], kind_count[KIND_ESCAPE]);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
